[sv/abb_pkg.sv]
package abb_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 13;
    localparam int unsigned DimW = 13;
    localparam int unsigned PixW = 32;
    localparam int unsigned IndexW = 24;
    localparam int unsigned ChanW = 8;
    localparam int unsigned SumW = 16;
    localparam int unsigned RecipW = 16;

    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_OFFSET_X = 3'd0;
    localparam t_cfg_idx CFG_OFFSET_Y = 3'd1;
    localparam t_cfg_idx CFG_DST_WIDTH = 3'd2;
    localparam t_cfg_idx CFG_DST_HEIGHT = 3'd3;
    localparam t_cfg_idx CFG_FAST_PATH = 3'd4;

    localparam logic [ChanW-1:0] ALPHA_SOLID = 8'hFC;
    localparam logic [ChanW-1:0] ALPHA_EMPTY = 8'h04;
    localparam logic [ChanW-1:0] ALPHA_FULL = 8'hFF;

    // floor(x / 255) == (x * 0x8081) >> 23 for every x below 65536
    localparam logic [RecipW-1:0] RECIP_255 = 16'h8081;
    localparam int unsigned RecipShift = 23;

    localparam logic [DimW-1:0] RST_WIDTH = 13'd640;
    localparam logic [DimW-1:0] RST_HEIGHT = 13'd480;

    typedef struct packed {
        logic              in_bounds;
        logic [IndexW-1:0] index;
    } t_pos;

    typedef struct packed {
        logic            skip;
        logic [PixW-1:0] pixel;
    } t_mix;

endpackage

[sv/abb_coord.sv]
module abb_coord
    import abb_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic signed [DimW-1:0] i_offset_x,
    input  logic signed [DimW-1:0] i_offset_y,
    input  logic [DimW-1:0]       i_dst_width,
    input  logic [DimW-1:0]       i_dst_height,
    input  logic [COORD_BITS-1:0] i_src_x,
    input  logic [COORD_BITS-1:0] i_src_y,
    output t_pos                  o_pos
);

    localparam int unsigned PosW = ((COORD_BITS > DimW) ? COORD_BITS : DimW) + 1;
    localparam int unsigned ProdW = 2 * DimW;

    logic signed [PosW-1:0] w_ox;
    logic signed [PosW-1:0] w_oy;
    logic signed [PosW-1:0] w_sx;
    logic signed [PosW-1:0] w_sy;
    logic signed [PosW-1:0] w_dx;
    logic signed [PosW-1:0] w_dy;
    logic [PosW-1:0]        w_width;
    logic [PosW-1:0]        w_height;
    logic                   w_inside;

    logic             r_inside1;
    logic [DimW-1:0]  r_dx1;
    logic [DimW-1:0]  r_dy1;
    logic             r_inside2;
    logic [DimW-1:0]  r_dx2;
    logic [ProdW-1:0] r_prod2;
    t_pos             r_pos3;

    assign w_ox = PosW'(i_offset_x);
    assign w_oy = PosW'(i_offset_y);
    assign w_sx = PosW'(i_src_x);
    assign w_sy = PosW'(i_src_y);
    assign w_dx = w_ox + w_sx;
    assign w_dy = w_oy + w_sy;
    assign w_width = PosW'(i_dst_width);
    assign w_height = PosW'(i_dst_height);

    assign w_inside = !w_dx[PosW-1] && !w_dy[PosW-1] &&
                      ($unsigned(w_dx) < w_width) && ($unsigned(w_dy) < w_height);

    always_ff @(posedge i_clk) begin
        r_inside1 <= w_inside;
        r_dx1 <= w_dx[DimW-1:0];
        r_dy1 <= w_dy[DimW-1:0];

        r_inside2 <= r_inside1;
        r_dx2 <= r_dx1;
        r_prod2 <= r_dy1 * i_dst_width;

        r_pos3.in_bounds <= r_inside2;
        r_pos3.index <= IndexW'(r_dx2) + r_prod2[IndexW-1:0];
    end

    assign o_pos = r_pos3;

endmodule

[sv/abb_mix.sv]
module abb_mix
    import abb_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_fast_path,
    input  logic [PixW-1:0] i_src_pixel,
    input  logic [PixW-1:0] i_dst_pixel,
    output t_mix            o_mix
);

    localparam int unsigned NumChan = 3;
    localparam int unsigned QuotW = 2 * RecipW;

    logic [ChanW-1:0] w_alpha;
    logic [ChanW-1:0] w_inv;

    logic             r_copy1;
    logic             r_skip1;
    logic [PixW-1:0]  r_src1;
    logic [SumW-1:0]  r_ps1 [NumChan];
    logic [SumW-1:0]  r_pd1 [NumChan];

    logic             r_copy2;
    logic             r_skip2;
    logic [PixW-1:0]  r_src2;
    logic [SumW-1:0]  r_sum2 [NumChan];

    logic [ChanW-1:0] w_q [NumChan];
    t_mix             r_mix3;

    assign w_alpha = i_src_pixel[PixW-1 -: ChanW];
    assign w_inv = ALPHA_FULL - w_alpha;

    genvar c;
    generate
        for (c = 0; c < NumChan; c++) begin : g_chan
            logic [QuotW-1:0] w_prod;

            assign w_prod = r_sum2[c] * RECIP_255;
            assign w_q[c] = w_prod[RecipShift +: ChanW];

            always_ff @(posedge i_clk) begin
                r_ps1[c] <= i_src_pixel[c*ChanW +: ChanW] * w_alpha;
                r_pd1[c] <= i_dst_pixel[c*ChanW +: ChanW] * w_inv;
                r_sum2[c] <= r_ps1[c] + r_pd1[c];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_copy1 <= i_fast_path && (w_alpha > ALPHA_SOLID);
        r_skip1 <= i_fast_path && (w_alpha < ALPHA_EMPTY);
        r_src1 <= i_src_pixel;

        r_copy2 <= r_copy1;
        r_skip2 <= r_skip1;
        r_src2 <= r_src1;

        r_mix3.skip <= r_skip2;
        if (r_copy2) begin
            r_mix3.pixel <= r_src2;
        end else begin
            r_mix3.pixel <= {ALPHA_FULL, w_q[2], w_q[1], w_q[0]};
        end
    end

    assign o_mix = r_mix3;

endmodule

[sv/alpha_blend_blit_pixel_core.sv]
// channel    direction  handshake                 payload
// request    in         start, busy               i_src_pixel, i_dst_pixel, i_src_x, i_src_y
// result     out        o_done (one-cycle strobe) o_write_enable, o_dst_index, o_out_pixel
// config     in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request per clock; busy stays low. Each result is registered through the
// multiply / sum / reciprocal-multiply / output register chain.
// Reset (synchronous, i_rst_n low) clears the valid chain and loads register defaults.
// The receiver cannot stall, so the pipeline advances every cycle.
module alpha_blend_blit_pixel_core
    import abb_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PixW-1:0]       i_src_pixel,
    input  logic [PixW-1:0]       i_dst_pixel,
    input  logic [COORD_BITS-1:0] i_src_x,
    input  logic [COORD_BITS-1:0] i_src_y,
    output logic                  o_done,
    output logic                  o_write_enable,
    output logic [IndexW-1:0]     o_dst_index,
    output logic [PixW-1:0]       o_out_pixel,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CfgDataW-1:0]   i_cfg_data
);

    localparam int unsigned Depth = 3;

    logic signed [DimW-1:0] r_offset_x;
    logic signed [DimW-1:0] r_offset_y;
    logic [DimW-1:0]        r_dst_width;
    logic [DimW-1:0]        r_dst_height;
    logic                   r_fast_path;

    logic [Depth-1:0] r_valid;
    logic             r_done;
    logic             r_we;
    logic [IndexW-1:0] r_index;
    logic [PixW-1:0]  r_pixel;

    t_pos w_pos;
    t_mix w_mix;
    logic w_we;

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_dst_width <= RST_WIDTH;
            r_dst_height <= RST_HEIGHT;
            r_fast_path <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFFSET_X:   r_offset_x <= i_cfg_data;
                CFG_OFFSET_Y:   r_offset_y <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_width <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                CFG_FAST_PATH:  r_fast_path <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    abb_coord #(
        .COORD_BITS(COORD_BITS)
    ) u_coord (
        .i_clk       (i_clk),
        .i_offset_x  (r_offset_x),
        .i_offset_y  (r_offset_y),
        .i_dst_width (r_dst_width),
        .i_dst_height(r_dst_height),
        .i_src_x     (i_src_x),
        .i_src_y     (i_src_y),
        .o_pos       (w_pos)
    );

    abb_mix u_mix (
        .i_clk      (i_clk),
        .i_fast_path(r_fast_path),
        .i_src_pixel(i_src_pixel),
        .i_dst_pixel(i_dst_pixel),
        .o_mix      (w_mix)
    );

    assign w_we = w_pos.in_bounds && !w_mix.skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done <= 1'b0;
        end else begin
            r_valid <= {r_valid[Depth-2:0], start && !busy};
            r_done <= r_valid[Depth-1];
        end
        r_we <= w_we;
        r_index <= w_we ? w_pos.index : '0;
        r_pixel <= w_we ? w_mix.pixel : '0;
    end

    assign o_done = r_done;
    assign o_write_enable = r_we;
    assign o_dst_index = r_index;
    assign o_out_pixel = r_pixel;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
    import abb_pkg::*;
();

    localparam int CoordBits = 12;
    localparam int DrainCycles = 10;
    localparam int StallLimit = 1000;
    localparam int RandPhases = 10;
    localparam int PhaseItems = 80;
    localparam int CoordMax = (1 << CoordBits) - 1;
    localparam int DataMax = (1 << CfgDataW) - 1;
    localparam int CfgIdxMax = (1 << CfgIdxW) - 1;

    typedef struct packed {
        logic              we;
        logic [IndexW-1:0] idx;
        logic [PixW-1:0]   pix;
    } t_blit_res;

    typedef struct {
        int ox;
        int oy;
        int w;
        int h;
        bit fp;
    } t_blit_cfg;

    class blit_scoreboard;
        logic signed [DimW-1:0] off_x;
        logic signed [DimW-1:0] off_y;
        logic [DimW-1:0]        width;
        logic [DimW-1:0]        height;
        logic                   fast_path;
        t_blit_res              pending_pixels[$];
        int errors;
        int n_req;
        int n_res;
        int n_copy;
        int n_blend;
        int n_skip;
        int n_clip;
        int n_cfg;

        function new();
            off_x = '0;
            off_y = '0;
            width = RST_WIDTH;
            height = RST_HEIGHT;
            fast_path = 1'b1;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CfgDataW-1:0] data);
            n_cfg++;
            case (idx)
                CFG_OFFSET_X:   off_x = data;
                CFG_OFFSET_Y:   off_y = data;
                CFG_DST_WIDTH:  width = data;
                CFG_DST_HEIGHT: height = data;
                CFG_FAST_PATH:  fast_path = data[0];
                default: ;
            endcase
        endfunction

        function logic [ChanW-1:0] mix_chan(logic [ChanW-1:0] s, logic [ChanW-1:0] d,
                                            logic [ChanW-1:0] a);
            int unsigned v;
            v = (int'(d) * (int'(ALPHA_FULL) - int'(a)) + int'(s) * int'(a))
                / int'(ALPHA_FULL);
            return v[ChanW-1:0];
        endfunction

        function void log_request(logic [PixW-1:0] src, logic [PixW-1:0] dst,
                                  logic [CoordBits-1:0] x, logic [CoordBits-1:0] y);
            int              dx;
            int              dy;
            logic [ChanW-1:0] a;
            longint          lin;
            t_blit_res       r;
            dx = int'(off_x) + int'(x);
            dy = int'(off_y) + int'(y);
            a = src[PixW-1 -: ChanW];
            r = '0;
            if (dx < 0 || dy < 0 || dx >= int'(width) || dy >= int'(height)) begin
                n_clip++;
            end else if (fast_path && a > ALPHA_SOLID) begin
                r.we = 1'b1;
                r.pix = src;
                n_copy++;
            end else if (fast_path && a < ALPHA_EMPTY) begin
                n_skip++;
            end else begin
                r.we = 1'b1;
                r.pix = {ALPHA_FULL,
                         mix_chan(src[23:16], dst[23:16], a),
                         mix_chan(src[15:8], dst[15:8], a),
                         mix_chan(src[7:0], dst[7:0], a)};
                n_blend++;
            end
            if (r.we) begin
                lin = longint'(dx) + longint'(dy) * longint'(width);
                r.idx = lin[IndexW-1:0];
            end
            pending_pixels.push_back(r);
            n_req++;
        endfunction

        function void check_pixel(logic we, logic [IndexW-1:0] idx, logic [PixW-1:0] pix);
            t_blit_res e;
            n_res++;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result we=%b idx=%h pix=%h", $time, we, idx, pix);
                errors++;
                return;
            end
            e = pending_pixels.pop_front();
            if (we !== e.we) begin
                $display("%0t: write_enable expected %b actual %b", $time, e.we, we);
                errors++;
            end
            if (idx !== e.idx) begin
                $display("%0t: dst_index expected %h actual %h", $time, e.idx, idx);
                errors++;
            end
            if (pix !== e.pix) begin
                $display("%0t: out_pixel expected %h actual %h", $time, e.pix, pix);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [PixW-1:0]       i_src_pixel;
    logic [PixW-1:0]       i_dst_pixel;
    logic [CoordBits-1:0]  i_src_x;
    logic [CoordBits-1:0]  i_src_y;
    logic                  o_done;
    logic                  o_write_enable;
    logic [IndexW-1:0]     o_dst_index;
    logic [PixW-1:0]       o_out_pixel;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CfgDataW-1:0]   i_cfg_data;

    blit_scoreboard sb = new();
    int stall_cycles;
    int n_phases;

    alpha_blend_blit_pixel_core #(
        .COORD_BITS(CoordBits)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_src_pixel(i_src_pixel),
        .i_dst_pixel(i_dst_pixel),
        .i_src_x(i_src_x),
        .i_src_y(i_src_y),
        .o_done(o_done),
        .o_write_enable(o_write_enable),
        .o_dst_index(o_dst_index),
        .o_out_pixel(o_out_pixel),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // monitor: sampled values are the ones present before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (start && !busy) sb.log_request(i_src_pixel, i_dst_pixel, i_src_x, i_src_y);
            if (o_done) sb.check_pixel(o_write_enable, o_dst_index, o_out_pixel);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == StallLimit) begin
            $display("%0t: no progress for %0d cycles", $time, StallLimit);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_pixel(logic [PixW-1:0] src, logic [PixW-1:0] dst,
                              logic [CoordBits-1:0] x, logic [CoordBits-1:0] y);
        start <= 1'b1;
        i_src_pixel <= src;
        i_dst_pixel <= dst;
        i_src_x <= x;
        i_src_y <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_requests(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // caller lowers i_cfg_valid after the last write of a batch
    task automatic program_reg(t_cfg_idx idx, logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_cfg(t_blit_cfg c, bit unused_too);
        program_reg(CFG_OFFSET_X, CfgDataW'(c.ox));
        program_reg(CFG_OFFSET_Y, CfgDataW'(c.oy));
        program_reg(CFG_DST_WIDTH, CfgDataW'(c.w));
        program_reg(CFG_DST_HEIGHT, CfgDataW'(c.h));
        program_reg(CFG_FAST_PATH, CfgDataW'(c.fp));
        if (unused_too) begin
            for (int k = int'(CFG_FAST_PATH) + 1; k <= CfgIdxMax; k++) begin
                program_reg(t_cfg_idx'(k), CfgDataW'($urandom_range(0, DataMax)));
            end
        end
        i_cfg_valid <= 1'b0;
        n_phases++;
    endtask

    function automatic logic [PixW-1:0] rand_pixel();
        logic [ChanW-1:0] a;
        case ($urandom_range(0, 5))
            0: a = ChanW'($urandom_range(0, int'(ALPHA_EMPTY)));
            1: a = ChanW'($urandom_range(int'(ALPHA_SOLID), int'(ALPHA_FULL)));
            2: a = $urandom_range(0, 1) ? ALPHA_SOLID : ALPHA_EMPTY - 8'd1;
            default: a = ChanW'($urandom);
        endcase
        return {a, 24'($urandom)};
    endfunction

    // mostly lands in or just around the destination window, often on its edges, the rest anywhere
    function automatic logic [CoordBits-1:0] pick_coord(int off, int span);
        int t;
        int c;
        c = $urandom_range(0, CoordMax);
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
                0: t = -1;
                1: t = 0;
                2: t = span - 1;
                3: t = span;
                default: t = int'($urandom_range(0, span + 7)) - 4;
            endcase
            if (t - off >= 0 && t - off <= CoordMax) c = t - off;
        end
        return c[CoordBits-1:0];
    endfunction

    task automatic run_phase(t_blit_cfg c, int count, bit idling, bit mid_drain);
        int quiet;
        quiet = 0;
        for (int i = 0; i < count; i++) begin
            if (mid_drain && i == count / 2) wait_all_results();
            if (quiet > 0) begin
                quiet--;
            end else if ($urandom_range(0, 29) == 0) begin
                quiet = $urandom_range(10, 30);
            end else if (idling && $urandom_range(0, 4) == 0) begin
                hold_requests($urandom_range(1, 18));
            end
            send_pixel(rand_pixel(), $urandom, pick_coord(c.ox, c.w), pick_coord(c.oy, c.h));
        end
        wait_all_results();
    endtask

    initial begin
        t_blit_cfg fixed[6];
        t_blit_cfg c;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_src_pixel <= '0;
        i_dst_pixel <= '0;
        i_src_x <= '0;
        i_src_y <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_OFFSET_X;
        i_cfg_data <= '0;
        n_phases = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: 640x480, fast paths on
        send_pixel({ALPHA_FULL, 24'hFFFFFF}, '0, 0, 0);
        send_pixel({ALPHA_SOLID + 8'd1, 24'h123456}, 32'h00ABCDEF, 639, 479);
        send_pixel({ALPHA_SOLID, 24'hFFFFFF}, '0, 639, 0);
        send_pixel({ALPHA_EMPTY, 24'hFF00FF}, 32'h1200FF00, 1, 1);
        send_pixel({ALPHA_EMPTY - 8'd1, 24'h778899}, 32'h55555555, 2, 2);
        send_pixel({8'h00, 24'hFFFFFF}, '1, 3, 3);
        send_pixel({ALPHA_FULL, 24'h0A0B0C}, '0, 640, 0);
        send_pixel({ALPHA_FULL, 24'h0A0B0C}, '0, 0, 480);
        send_pixel('1, '1, CoordBits'(CoordMax), CoordBits'(CoordMax));
        send_pixel({8'h80, 24'hFFFFFF}, '0, 100, 200);
        send_pixel({8'h80, 24'h000000}, '1, 101, 200);
        send_pixel({8'h7F, 24'h8040C0}, 32'hA5C3E10F, 320, 240);
        send_pixel('1, '1, 0, 479);
        send_pixel('0, '0, 639, 479);
        wait_all_results();

        program_reg(CFG_FAST_PATH, '0);
        i_cfg_valid <= 1'b0;
        send_pixel({8'h00, 24'h102030}, 32'h00405060, 5, 5);
        send_pixel({ALPHA_FULL, 24'hF0E0D0}, 32'h00010203, 6, 5);
        send_pixel({ALPHA_SOLID + 8'd1, 24'h00FF00}, 32'hFF00FF00, 7, 5);
        send_pixel({ALPHA_EMPTY - 8'd1, 24'hFFFFFF}, 32'h00000000, 8, 5);
        wait_all_results();

        program_reg(CFG_OFFSET_X, '1);
        program_reg(CFG_OFFSET_Y, '1);
        i_cfg_valid <= 1'b0;
        send_pixel(rand_pixel(), $urandom, 0, 5);
        send_pixel(rand_pixel(), $urandom, 1, 1);
        send_pixel({8'h40, 24'h336699}, $urandom, 640, 480);
        send_pixel({8'h40, 24'h336699}, $urandom, 641, 1);
        wait_all_results();

        fixed[0] = '{0, 0, 640, 480, 1'b1};
        fixed[1] = '{-4096, -4096, 4096, 4096, 1'b0};
        fixed[2] = '{4095, 4095, 4096, 4096, 1'b1};
        fixed[3] = '{-37, 21, 1, 1, 1'b1};
        fixed[4] = '{3, 0, 0, 64, 1'b0};
        fixed[5] = '{12, -7, DataMax, DataMax, 1'b0};
        for (int p = 0; p < RandPhases; p++) begin
            if (p < 6) begin
                c = fixed[p];
            end else begin
                c.ox = int'($urandom_range(0, DataMax)) - 4096;
                c.oy = int'($urandom_range(0, DataMax)) - 4096;
                c.w = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
                c.h = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
                c.fp = 1'($urandom_range(0, 1));
                if (p == 7) c.h = 0;
            end
            apply_cfg(c, p == 1);
            run_phase(c, PhaseItems, p != 3 && p != RandPhases - 1, p == 0);
        end

        if (sb.pending_pixels.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     sb.pending_pixels.size());
            sb.errors += sb.pending_pixels.size();
        end
        $display("Ran %0d pixels over %0d register settings (%0d writes)",
                 sb.n_req, n_phases, sb.n_cfg);
        $display("Blended %0d, copied %0d, skipped %0d, clipped %0d, results seen %0d",
                 sb.n_blend, sb.n_copy, sb.n_skip, sb.n_clip, sb.n_res);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
